@@ rtl/core/trs_pkg.sv @@
// package for the trapezoidal reference smoother: constants, types, states
`timescale 1ns / 1ps

package trs_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_WIDTH  = 31;
    localparam int DT_WIDTH   = 17;

    localparam logic [1:0] REG_MAX_VEL = 2'd0;
    localparam logic [1:0] REG_MAX_ACC = 2'd1;
    localparam logic [1:0] REG_DT      = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_VEL,
        ST_POS1,
        ST_POS2,
        ST_ERR,
        ST_SQRT,
        ST_ACC,
        ST_DIV,
        ST_DONE
    } state_t;

    // request to the shared iterative unit
    typedef struct packed {
        logic        start;
        logic [1:0]  op;
    } unit_req_t;

    localparam logic [1:0] OP_MUL  = 2'd0;
    localparam logic [1:0] OP_SQRT = 2'd1;
    localparam logic [1:0] OP_DIV  = 2'd2;

endpackage

@@ rtl/core/trs_unit.sv @@
// shared shift-add unit: multiply, square root and divide, one bit per cycle
`timescale 1ns / 1ps

module trs_unit #(
    parameter int W = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  trs_pkg::unit_req_t  req,
    input  logic [W-1:0]        a,
    input  logic [W-1:0]        b,
    output logic                busy,
    output logic [2*W-1:0]      result
);
    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] acc_reg, acc_next;
    logic [W-1:0]   opa_reg, opa_next;
    logic [W-1:0]   opb_reg, opb_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [1:0]     op_reg, op_next;
    logic           busy_reg, busy_next;
    logic [W+1:0]   trial;
    logic [W:0]     dtrial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        opa_reg <= opa_next;
        opb_reg <= opb_next;
        rem_reg <= rem_next;
        op_reg  <= op_next;
    end

    always_comb begin
        acc_next  = acc_reg;
        opa_next  = opa_reg;
        opb_next  = opb_reg;
        rem_next  = rem_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        trial     = '0;
        dtrial    = '0;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            opa_next  = a;
            opb_next  = b;
            rem_next  = '0;
            acc_next  = '0;
            case (req.op)
                trs_pkg::OP_SQRT: cnt_next = CW'(W / 2);
                default:          cnt_next = CW'(W);
            endcase
        end else if (busy_reg) begin
            case (op_reg)
                trs_pkg::OP_MUL: begin
                    // accumulate from the msb of b
                    acc_next = {acc_reg[2*W-2:0], 1'b0}
                             + (opb_reg[W-1] ? {{W{1'b0}}, opa_reg} : '0);
                    opb_next = {opb_reg[W-2:0], 1'b0};
                end
                trs_pkg::OP_SQRT: begin
                    // two radicand bits per step, restoring
                    trial = {rem_reg, opa_reg[W-1:W-2]} - {acc_reg[W-1:0], 2'b01};
                    if (!trial[W+1]) begin
                        rem_next = trial[W-1:0];
                        acc_next = {acc_reg[2*W-2:0], 1'b1};
                    end else begin
                        rem_next = {rem_reg[W-3:0], opa_reg[W-1:W-2]};
                        acc_next = {acc_reg[2*W-2:0], 1'b0};
                    end
                    opa_next = {opa_reg[W-3:0], 2'b00};
                end
                default: begin
                    dtrial = {rem_reg, opa_reg[W-1]} - {1'b0, opb_reg};
                    if (!dtrial[W]) begin
                        rem_next = dtrial[W-1:0];
                        acc_next = {acc_reg[2*W-2:0], 1'b1};
                    end else begin
                        rem_next = {rem_reg[W-2:0], opa_reg[W-1]};
                        acc_next = {acc_reg[2*W-2:0], 1'b0};
                    end
                    opa_next = {opa_reg[W-2:0], 1'b0};
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) busy_next = 1'b0;
        end
    end

    assign busy   = busy_reg;
    assign result = acc_reg;

    property p_cnt_idle;
        @(posedge aclk) disable iff (!aresetn) !busy_reg |-> cnt_reg == '0;
    endproperty
    a_cnt_idle: assert property (p_cnt_idle) else $error("counter not zero while idle");

    property p_busy_drop;
        @(posedge aclk) disable iff (!aresetn)
            $fell(busy_reg) |-> $past(cnt_reg) == CW'(1);
    endproperty
    a_busy_drop: assert property (p_busy_drop) else $error("unit finished early");

    property p_start_sets;
        @(posedge aclk) disable iff (!aresetn) req.start |=> busy_reg;
    endproperty
    a_start_sets: assert property (p_start_sets) else $error("start did not raise busy");

endmodule

@@ rtl/core/trapezoidal_reference_smoother.sv @@
// top level: trapezoidal reference smoother with a shared iterative unit
//
//  channel | ports                          | transfer
//  in      | s_valid s_ready s_mode s_goal  | valid/ready, load_* used when mode set
//  out     | m_valid m_ready m_out_*        | valid/ready, one result per input
//  cfg     | cfg_we cfg_index cfg_data      | write on enable, no wait
//
// at 32 bits, one transaction from acceptance to the result handshake uses up to eight
// multiplies and one divide on 64-bit operands at one bit per cycle and a 32-step
// square root. a snap skips all work after the snap test; outside the braking zone
// the root is skipped. s_ready is low from acceptance until the result is taken;
// m_valid rises in the cycle after the done state is entered. reset loads the
// default limits and clears the reference.
`timescale 1ns / 1ps

module trapezoidal_reference_smoother #(
    parameter int DATA_WIDTH = trs_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = trs_pkg::FRAC_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [trs_pkg::CFG_WIDTH-1:0] cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic signed [31:0]           s_goal,
    input  logic signed [31:0]           s_load_pos,
    input  logic signed [31:0]           s_load_vel,
    input  logic signed [31:0]           s_load_acc,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [31:0]           m_out_pos,
    output logic signed [31:0]           m_out_vel,
    output logic signed [31:0]           m_out_acc,
    output logic                         m_at_goal,
    output logic                         m_clipped
);
    localparam int D  = DATA_WIDTH;
    // wide enough for 2*|err|*A and for dt squared
    localparam int UW = (2 * D > 2 * trs_pkg::DT_WIDTH) ? 2 * D : 2 * trs_pkg::DT_WIDTH;
    localparam logic [D-1:0] VMAX = {1'b0, {(D-1){1'b1}}};
    localparam logic [D-1:0] VMIN = {1'b1, {(D-1){1'b0}}};
    localparam int CWD = trs_pkg::CFG_WIDTH;

    trs_pkg::state_t state_reg, state_next;
    logic [CWD-1:0] vlim_reg, alim_reg;
    logic [trs_pkg::DT_WIDTH-1:0] dt_reg;
    logic signed [D-1:0] pos_reg, pos_next, vel_reg, vel_next, acc_reg, acc_next;
    logic signed [D-1:0] goal_reg, goal_next, err_reg, err_next;
    logic [UW-1:0] thr_reg, thr_next;     // scratch: A*dt rounded, then 2|err|A, then vd magnitude
    logic [2:0] sub_reg, sub_next;        // multiply phase inside a state
    logic clip_reg, clip_next, snap_reg, snap_next, mv_reg, mv_next;

    trs_pkg::unit_req_t req;
    logic [UW-1:0] ua, ub;
    logic ubusy;
    logic [2*UW-1:0] ures;

    trs_unit #(.W(UW)) u_unit (
        .aclk(aclk), .aresetn(aresetn), .req(req), .a(ua), .b(ub),
        .busy(ubusy), .result(ures)
    );

    logic [UW-1:0] vlim_w, alim_w, dt_w, dt2_w;
    logic [2*trs_pkg::DT_WIDTH-1:0] dt_sq;
    always_comb begin
        // limits clamp to the largest positive data value
        vlim_w = (UW'(vlim_reg) > UW'(VMAX)) ? UW'(VMAX) : UW'(vlim_reg);
        alim_w = (UW'(alim_reg) > UW'(VMAX)) ? UW'(VMAX) : UW'(alim_reg);
        dt_w   = UW'(dt_reg);
        dt_sq  = dt_reg * dt_reg;
        dt2_w  = UW'(dt_sq);
    end

    function automatic logic [UW-1:0] mag_f(input logic signed [D-1:0] x);
        logic [D-1:0] t;
        t = x[D-1] ? (~x + 1'b1) : x;
        return UW'(t);
    endfunction

    // round half up at shift sh, saturated to UW bits
    function automatic logic [UW-1:0] rnd_f(input logic [2*UW-1:0] p, input int sh);
        logic [2*UW:0] s;
        s = ({1'b0, p} + ((2*UW+1)'(1) << (sh - 1))) >> sh;
        return (s[2*UW:UW] != '0) ? {UW{1'b1}} : s[UW-1:0];
    endfunction

    // sign applied to magnitude with saturation; returns {clip, value}
    function automatic logic [D:0] fmag_f(input logic neg, input logic [UW-1:0] m);
        if (neg) begin
            if (m > UW'(VMAX) + 1'b1) return {1'b1, VMIN};
            if (m > UW'(VMAX)) return {1'b0, VMIN};
            return {1'b0, D'(~m + 1'b1)};
        end
        if (m > UW'(VMAX)) return {1'b1, VMAX};
        return {1'b0, m[D-1:0]};
    endfunction

    function automatic logic [D:0] sadd_f(input logic signed [D-1:0] x,
                                          input logic signed [D-1:0] y);
        logic signed [D:0] s;
        s = {x[D-1], x} + {y[D-1], y};
        if (s[D] != s[D-1]) return {1'b1, s[D] ? VMIN : VMAX};
        return {1'b0, s[D-1:0]};
    endfunction

    function automatic logic [D:0] ssub_f(input logic signed [D-1:0] x,
                                          input logic signed [D-1:0] y);
        logic signed [D:0] s;
        s = {x[D-1], x} - {y[D-1], y};
        if (s[D] != s[D-1]) return {1'b1, s[D] ? VMIN : VMAX};
        return {1'b0, s[D-1:0]};
    endfunction

    // 32-bit input to D bits with saturation; returns {clip, value}
    function automatic logic [D:0] fit_f(input logic signed [31:0] x);
        logic signed [63:0] w;
        w = 64'(x);
        if (w > 64'(signed'(VMAX))) return {1'b1, VMAX};
        if (w < -64'(signed'(VMAX)) - 64'sd1) return {1'b1, VMIN};
        return {1'b0, D'(w)};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= trs_pkg::ST_IDLE;
            vlim_reg  <= CWD'(65536);
            alim_reg  <= CWD'(65536);
            dt_reg    <= trs_pkg::DT_WIDTH'(655);
            pos_reg   <= '0;
            vel_reg   <= '0;
            acc_reg   <= '0;
            mv_reg    <= 1'b0;
            sub_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            vel_reg   <= vel_next;
            acc_reg   <= acc_next;
            mv_reg    <= mv_next;
            sub_reg   <= sub_next;
            if (cfg_we) begin
                case (cfg_index)
                    trs_pkg::REG_MAX_VEL: vlim_reg <= cfg_data;
                    trs_pkg::REG_MAX_ACC: alim_reg <= cfg_data;
                    trs_pkg::REG_DT:      dt_reg   <= cfg_data[trs_pkg::DT_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
        goal_reg <= goal_next;
        err_reg  <= err_next;
        thr_reg  <= thr_next;
        clip_reg <= clip_next;
        snap_reg <= snap_next;
    end

    logic [D:0] t1, t2, t3;
    logic [UW-1:0] vmag, emag;

    always_comb begin
        state_next = state_reg;
        pos_next = pos_reg; vel_next = vel_reg; acc_next = acc_reg;
        goal_next = goal_reg; err_next = err_reg; thr_next = thr_reg;
        clip_next = clip_reg; snap_next = snap_reg; mv_next = mv_reg;
        sub_next = sub_reg;
        req = '{start: 1'b0, op: trs_pkg::OP_MUL};
        ua = '0; ub = '0;
        t1 = '0; t2 = '0; t3 = '0;
        vmag = mag_f(vel_reg); emag = mag_f(err_reg);
        s_ready = 1'b0;
        case (state_reg)
            trs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    t1 = fit_f(s_goal);
                    goal_next = t1[D-1:0];
                    clip_next = t1[D];
                    snap_next = 1'b0;
                    if (s_mode) begin
                        t1 = fit_f(s_load_pos); pos_next = t1[D-1:0];
                        t2 = fit_f(s_load_vel); vel_next = t2[D-1:0];
                        t3 = fit_f(s_load_acc); acc_next = t3[D-1:0];
                        clip_next = clip_next | t1[D] | t2[D] | t3[D];
                    end
                    sub_next = '0;
                    state_next = trs_pkg::ST_VEL;
                end
            end
            trs_pkg::ST_VEL: begin
                // |acc|*dt
                if (sub_reg == 3'd0) begin
                    req = '{start: 1'b1, op: trs_pkg::OP_MUL};
                    ua = mag_f(acc_reg); ub = dt_w; sub_next = 3'd1;
                end else if (sub_reg == 3'd2 && !ubusy) begin
                    t1 = fmag_f(acc_reg[D-1], rnd_f(ures, FRAC_BITS));
                    t2 = sadd_f(vel_reg, t1[D-1:0]);
                    vel_next = t2[D-1:0];
                    clip_next = clip_reg | t1[D] | t2[D];
                    sub_next = '0;
                    state_next = trs_pkg::ST_POS1;
                end else sub_next = 3'd2;
            end
            trs_pkg::ST_POS1: begin
                if (sub_reg == 3'd0) begin
                    req = '{start: 1'b1, op: trs_pkg::OP_MUL};
                    ua = vmag; ub = dt_w; sub_next = 3'd1;
                end else if (sub_reg == 3'd2 && !ubusy) begin
                    t1 = fmag_f(vel_reg[D-1], rnd_f(ures, FRAC_BITS));
                    t2 = sadd_f(pos_reg, t1[D-1:0]);
                    pos_next = t2[D-1:0];
                    clip_next = clip_reg | t1[D] | t2[D];
                    sub_next = '0;
                    state_next = trs_pkg::ST_POS2;
                end else sub_next = 3'd2;
            end
            trs_pkg::ST_POS2: begin
                if (sub_reg == 3'd0) begin
                    req = '{start: 1'b1, op: trs_pkg::OP_MUL};
                    ua = mag_f(acc_reg); ub = dt2_w; sub_next = 3'd1;
                end else if (sub_reg == 3'd2 && !ubusy) begin
                    t1 = fmag_f(acc_reg[D-1], rnd_f(ures, 2*FRAC_BITS+1));
                    t2 = sadd_f(pos_reg, t1[D-1:0]);
                    pos_next = t2[D-1:0];
                    t3 = ssub_f(t2[D-1:0], goal_reg);
                    err_next = t3[D-1:0];
                    clip_next = clip_reg | t1[D] | t2[D] | t3[D];
                    sub_next = '0;
                    state_next = trs_pkg::ST_ERR;
                end else sub_next = 3'd2;
            end
            trs_pkg::ST_ERR: begin
                // A*dt, A*dt^2 for the snap test, then 2|err|A
                case (sub_reg)
                    3'd0: begin
                        req = '{start: 1'b1, op: trs_pkg::OP_MUL};
                        ua = alim_w; ub = dt_w; sub_next = 3'd1;
                    end
                    3'd1: sub_next = 3'd2;
                    3'd2: if (!ubusy) begin
                        thr_next = rnd_f(ures, FRAC_BITS);
                        req = '{start: 1'b1, op: trs_pkg::OP_MUL};
                        ua = alim_w; ub = dt2_w; sub_next = 3'd3;
                    end
                    3'd3: sub_next = 3'd4;
                    3'd4: if (!ubusy) begin
                        if (vmag <= thr_reg && emag <= rnd_f(ures, 2*FRAC_BITS+1)) begin
                            snap_next = 1'b1;
                            pos_next = goal_reg; vel_next = '0; acc_next = '0;
                            state_next = trs_pkg::ST_DONE;
                            sub_next = '0;
                        end else begin
                            req = '{start: 1'b1, op: trs_pkg::OP_MUL};
                            ua = emag; ub = {alim_w[UW-2:0], 1'b0}; sub_next = 3'd5;
                        end
                    end
                    3'd5: sub_next = 3'd6;
                    default: if (!ubusy) begin
                        thr_next = ures[UW-1:0];   // 2|err|A, below 2^(2D-1)
                        sub_next = '0;
                        state_next = trs_pkg::ST_SQRT;
                    end
                endcase
            end
            trs_pkg::ST_SQRT: begin
                case (sub_reg)
                    3'd0: begin
                        req = '{start: 1'b1, op: trs_pkg::OP_MUL};
                        ua = vlim_w; ub = vlim_w; sub_next = 3'd1;
                    end
                    3'd1: sub_next = 3'd2;
                    3'd2: if (!ubusy) begin
                        if (alim_w != '0 && thr_reg < ures[UW-1:0]) begin
                            req = '{start: 1'b1, op: trs_pkg::OP_SQRT};
                            ua = thr_reg; sub_next = 3'd3;
                        end else begin
                            thr_next = vlim_w; sub_next = '0;
                            state_next = trs_pkg::ST_ACC;
                        end
                    end
                    3'd3: sub_next = 3'd4;
                    default: if (!ubusy) begin
                        thr_next = ures[UW-1:0]; sub_next = '0;
                        state_next = trs_pkg::ST_ACC;
                    end
                endcase
            end
            trs_pkg::ST_ACC: begin
                t1 = fmag_f(!err_reg[D-1], thr_reg);
                t2 = ssub_f(t1[D-1:0], vel_reg);
                case (sub_reg)
                    3'd0: begin
                        clip_next = clip_reg | t2[D];
                        err_next = t2[D-1:0];    // holds dv from here on
                        req = '{start: 1'b1, op: trs_pkg::OP_MUL};
                        ua = alim_w; ub = dt_w; sub_next = 3'd1;
                    end
                    3'd1: sub_next = 3'd2;
                    default: if (!ubusy) begin
                        sub_next = '0;
                        if ((UW'(emag) << FRAC_BITS) >= ures[UW-1:0]
                            || (emag >> (UW - FRAC_BITS)) != '0) begin
                            acc_next = err_reg[D-1] ? D'(~alim_w + 1'b1) : alim_w[D-1:0];
                            state_next = trs_pkg::ST_DONE;
                        end else state_next = trs_pkg::ST_DIV;
                    end
                endcase
            end
            trs_pkg::ST_DIV: begin
                case (sub_reg)
                    3'd0: begin
                        req = '{start: 1'b1, op: trs_pkg::OP_DIV};
                        ua = emag << FRAC_BITS; ub = dt_w; sub_next = 3'd1;
                    end
                    3'd1: sub_next = 3'd2;
                    default: if (!ubusy) begin
                        acc_next = err_reg[D-1] ? D'(~ures[UW-1:0] + 1'b1) : ures[D-1:0];
                        sub_next = '0;
                        state_next = trs_pkg::ST_DONE;
                    end
                endcase
            end
            trs_pkg::ST_DONE: begin
                mv_next = 1'b1;
                if (mv_reg && m_ready) begin
                    mv_next = 1'b0;
                    state_next = trs_pkg::ST_IDLE;
                end
            end
            default: state_next = trs_pkg::ST_IDLE;
        endcase
    end

    assign m_valid   = mv_reg;
    assign m_out_pos = 32'(pos_reg);
    assign m_out_vel = 32'(vel_reg);
    assign m_out_acc = 32'(acc_reg);
    assign m_at_goal = snap_reg;
    assign m_clipped = clip_reg;

    property p_valid_done;
        @(posedge aclk) disable iff (!aresetn) mv_reg |-> state_reg == trs_pkg::ST_DONE;
    endproperty
    a_valid_done: assert property (p_valid_done) else $error("result outside done state");

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn) s_ready |-> !mv_reg && !ubusy;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while working");

    property p_snap_zero;
        @(posedge aclk) disable iff (!aresetn)
            mv_reg && snap_reg |-> vel_reg == '0 && acc_reg == '0;
    endproperty
    a_snap_zero: assert property (p_snap_zero) else $error("snap left motion");

endmodule

@@ sim/trapezoidal_reference_smoother_tb.sv @@
// testbench for the trapezoidal reference smoother: directed table plus random ticks
`timescale 1ns / 1ps

module trapezoidal_reference_smoother_tb;

    typedef bit [127:0] wide_t;

    typedef struct {
        bit                 mode;
        logic signed [31:0] goal;
        logic signed [31:0] load_pos;
        logic signed [31:0] load_vel;
        logic signed [31:0] load_acc;
        bit                 typed;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        bit                 at_goal;
        bit                 clipped;
    } tick_t;

    typedef struct {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        bit                 at_goal;
        bit                 clipped;
    } motion_t;

    localparam longint TOP = 64'sd2147483647;
    localparam longint BOT = -64'sd2147483648;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [1:0]           cfg_index = trs_pkg::REG_MAX_VEL;
    logic [trs_pkg::CFG_WIDTH-1:0] cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_mode = 1'b0;
    logic signed [31:0]   s_goal = '0;
    logic signed [31:0]   s_load_pos = '0;
    logic signed [31:0]   s_load_vel = '0;
    logic signed [31:0]   s_load_acc = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic signed [31:0]   m_out_pos;
    logic signed [31:0]   m_out_vel;
    logic signed [31:0]   m_out_acc;
    logic                 m_at_goal;
    logic                 m_clipped;

    // predictor copy of the limits and the reference
    longint unsigned lim_vel = 65536;
    longint unsigned lim_acc = 65536;
    longint unsigned tick_dt = 655;
    longint          cur_pos = 0;
    longint          cur_vel = 0;
    longint          cur_acc = 0;

    motion_t expected_motion[$];
    tick_t   offered;
    int      errors = 0;
    int      hold_cycles = 0;
    bit      no_gaps = 1'b0;

    trapezoidal_reference_smoother DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint clamp(longint a, inout bit clip);
        if (a > TOP) begin clip = 1'b1; return TOP; end
        if (a < BOT) begin clip = 1'b1; return BOT; end
        return a;
    endfunction

    function automatic longint unsigned magn(longint a);
        return a < 0 ? longint'(-a) : a;
    endfunction

    // rounded (a*b) >> sh, saturating at 64 bits
    function automatic longint unsigned scale_round(longint unsigned a, longint unsigned b,
                                                    int sh);
        wide_t p;
        p = (wide_t'(a) * wide_t'(b) + (wide_t'(1) << (sh - 1))) >> sh;
        return p[127:64] != 0 ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    function automatic longint signed_of(bit neg, longint unsigned m, inout bit clip);
        if (neg) begin
            if (m > 64'd2147483648) clip = 1'b1;
            return m > 64'd2147483648 ? BOT : -longint'(m);
        end
        if (m > 64'd2147483647) begin clip = 1'b1; return TOP; end
        return longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned root = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= root + b) begin
                x -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic motion_t advance_reference(tick_t t);
        motion_t         r;
        bit              clip = 1'b0;
        bit              snap = 1'b0;
        longint unsigned dt2 = tick_dt * tick_dt;
        longint unsigned vd, dm;
        longint          pos, vel, acc, err, goal, vel_d, dv, delta;
        goal = t.goal;
        if (t.mode) begin
            cur_pos = t.load_pos;
            cur_vel = t.load_vel;
            cur_acc = t.load_acc;
        end
        pos = cur_pos; vel = cur_vel; acc = cur_acc;
        delta = signed_of(acc < 0, scale_round(magn(acc), tick_dt, trs_pkg::FRAC_BITS), clip);
        vel = clamp(vel + delta, clip);
        delta = signed_of(vel < 0, scale_round(magn(vel), tick_dt, trs_pkg::FRAC_BITS), clip);
        pos = clamp(pos + delta, clip);
        delta = signed_of(acc < 0, scale_round(magn(acc), dt2, 2 * trs_pkg::FRAC_BITS + 1),
                          clip);
        pos = clamp(pos + delta, clip);
        err = clamp(pos - goal, clip);
        if (magn(vel) <= scale_round(lim_acc, tick_dt, trs_pkg::FRAC_BITS) &&
            magn(err) <= scale_round(lim_acc, dt2, 2 * trs_pkg::FRAC_BITS + 1)) begin
            snap = 1'b1;
            pos = goal; vel = 0; acc = 0;
        end else begin
            vd = lim_vel;
            // braking zone: 2*|err|*A < V*V
            if (lim_acc != 0 &&
                wide_t'(2) * wide_t'(magn(err)) * wide_t'(lim_acc) <
                wide_t'(lim_vel) * wide_t'(lim_vel))
                vd = int_sqrt(2 * magn(err) * lim_acc);
            vel_d = err >= 0 ? -longint'(vd) : longint'(vd);
            dv = clamp(vel_d - vel, clip);
            dm = magn(dv);
            if ((wide_t'(dm) << trs_pkg::FRAC_BITS) >= wide_t'(lim_acc) * wide_t'(tick_dt))
                dm = lim_acc;
            else
                dm = (dm << trs_pkg::FRAC_BITS) / tick_dt;
            acc = dv < 0 ? -longint'(dm) : longint'(dm);
        end
        cur_pos = pos; cur_vel = vel; cur_acc = acc;
        r.pos = pos[31:0]; r.vel = vel[31:0]; r.acc = acc[31:0];
        r.at_goal = snap; r.clipped = clip;
        return r;
    endfunction

    // accepted input transaction: predict, or take the typed expectation
    always @(posedge aclk) begin
        motion_t r;
        if (aresetn && s_valid && s_ready) begin
            r = advance_reference(offered);
            if (offered.typed) begin
                r.pos = offered.pos; r.vel = offered.vel; r.acc = offered.acc;
                r.at_goal = offered.at_goal; r.clipped = offered.clipped;
            end
            expected_motion.push_back(r);
        end
    end

    // accepted result transaction
    always @(posedge aclk) begin
        motion_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_motion.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = expected_motion.pop_front();
                if (m_out_pos !== e.pos) begin
                    $error("out_pos expected %0d got %0d", e.pos, m_out_pos); errors++;
                end
                if (m_out_vel !== e.vel) begin
                    $error("out_vel expected %0d got %0d", e.vel, m_out_vel); errors++;
                end
                if (m_out_acc !== e.acc) begin
                    $error("out_acc expected %0d got %0d", e.acc, m_out_acc); errors++;
                end
                if (m_at_goal !== e.at_goal) begin
                    $error("at_goal expected %0b got %0b", e.at_goal, m_at_goal); errors++;
                end
                if (m_clipped !== e.clipped) begin
                    $error("clipped expected %0b got %0b", e.clipped, m_clipped); errors++;
                end
            end
        end
    end

    // result side: random stalls, and a long hold when asked
    initial begin
        int w;
        @(posedge aresetn);
        forever begin
            w = no_gaps ? 0 : $urandom_range(0, 7);
            if (hold_cycles > 0) begin
                w = hold_cycles;
                hold_cycles = 0;
            end
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    task automatic offer(tick_t t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        offered = t;
        s_mode <= t.mode;
        s_goal <= t.goal;
        s_load_pos <= t.load_pos;
        s_load_vel <= t.load_vel;
        s_load_acc <= t.load_acc;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // drop valid and wait for every outstanding result
    task automatic drain;
        s_valid <= 1'b0;
        wait (expected_motion.size() == 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(logic [1:0] idx, longint unsigned value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[trs_pkg::CFG_WIDTH-1:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            trs_pkg::REG_MAX_VEL: lim_vel = value & 64'h7FFF_FFFF;
            trs_pkg::REG_MAX_ACC: lim_acc = value & 64'h7FFF_FFFF;
            trs_pkg::REG_DT:      tick_dt = value & 64'h1_FFFF;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] rand_word();
        logic signed [31:0] v;
        v = $urandom();
        return v >>> $urandom_range(0, 31);
    endfunction

    task automatic random_ticks(int n);
        tick_t t;
        logic signed [31:0] target;
        int k;
        target = rand_word();
        for (k = 0; k < n; k++) begin
            t = '{default: '0};
            if ($urandom_range(0, 24) == 0) target = rand_word();
            case ($urandom_range(0, 9))
                0: begin
                    t.mode = 1'b1;
                    t.load_pos = rand_word();
                    t.load_vel = rand_word() >>> 8;
                    t.load_acc = rand_word() >>> 8;
                    t.goal = target;
                end
                1, 2: begin
                    t.mode = 1'($urandom_range(0, 1));
                    t.goal = $urandom();
                    t.load_pos = $urandom();
                    t.load_vel = $urandom();
                    t.load_acc = $urandom();
                    target = t.goal;
                end
                default: begin
                    t.goal = target;
                    t.load_pos = $urandom();
                    t.load_vel = $urandom();
                    t.load_acc = $urandom();
                end
            endcase
            offer(t);
        end
    endtask

    tick_t directed[] = '{
        // from reset everything is zero and sits on the goal
        '{0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0},
        '{1, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0},
        '{1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0},
        '{0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0},
        '{0, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0},
        '{1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0},
        // goal at the loaded position while moving fast: desired velocity goes negative
        '{1, 0, 0, 32'h0010_0000, 0, 0, 0, 0, 0, 0, 0},
        '{1, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0},
        '{0, 32'hFFF0_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 32'h0000_0100, 32'h0000_00FF, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 32'h0100_0000, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0},
        '{0, 32'h0100_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 0, 0, 0},
        '{1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 0, 0, 0, 0, 0, 0}
    };

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed[i]) offer(directed[i]);
        drain();

        // widest limits, one second step, with a long receiver stall
        write_limit(trs_pkg::REG_MAX_VEL, 64'h7FFF_FFFF);
        write_limit(trs_pkg::REG_MAX_ACC, 64'h7FFF_FFFF);
        write_limit(trs_pkg::REG_DT, 65536);
        hold_cycles = 3000;
        random_ticks(200);
        drain();

        // zero limits and the shortest step
        write_limit(trs_pkg::REG_MAX_VEL, 0);
        write_limit(trs_pkg::REG_MAX_ACC, 0);
        write_limit(trs_pkg::REG_DT, 1);
        no_gaps = 1'b1;
        random_ticks(120);
        drain();
        no_gaps = 1'b0;

        write_limit(trs_pkg::REG_DT, 0);
        random_ticks(60);
        drain();

        // moderate limits where trajectories reach their goals
        write_limit(trs_pkg::REG_MAX_VEL, 64'h0004_0000);
        write_limit(trs_pkg::REG_MAX_ACC, 64'h0002_0000);
        write_limit(trs_pkg::REG_DT, 16384);
        random_ticks(300);
        drain();

        write_limit(trs_pkg::REG_MAX_VEL, $urandom() & 32'h7FFF_FFFF);
        write_limit(trs_pkg::REG_MAX_ACC, $urandom() & 32'h7FFF_FFFF);
        write_limit(trs_pkg::REG_DT, $urandom_range(1, 65536));
        random_ticks(300);
        drain();

        repeat (500) @(posedge aclk);
        if (errors == 0 && expected_motion.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
